// ===== hdl/axt_pkg.sv =====
// Shared types and constants for the ADRP cross-reference tracker.
// Holds the instruction encodings and the decoded-item layout that the front
// end passes to the back end. No dependencies.
package axt_pkg;

   localparam int INSN_W      = 32;
   localparam int ADDR_W      = 64;
   localparam int REG_FIELD_W = 5;
   localparam int KIND_W      = 2;

   // Instruction encodings recognized by the tracker, as mask and pattern pairs.
   localparam logic [31:0] MASK_BRREG    = 32'hFFFFFC1F;
   localparam logic [31:0] OP_RET        = 32'hD65F0000;
   localparam logic [31:0] OP_BR         = 32'hD61F0000;
   localparam logic [31:0] OP_BLR        = 32'hD63F0000;
   localparam logic [31:0] MASK_HINT     = 32'hFFFFF01F;
   localparam logic [31:0] OP_HINT       = 32'hD503201F;
   localparam logic [31:0] MASK_ADR      = 32'h1F000000;
   localparam logic [31:0] OP_ADR        = 32'h10000000;
   localparam logic [31:0] OP_ADRP       = 32'h90000000;
   localparam logic [31:0] MASK_B        = 32'h7C000000;
   localparam logic [31:0] OP_B          = 32'h14000000;
   localparam logic [31:0] MASK_BCOND    = 32'hFF000010;
   localparam logic [31:0] OP_BCOND      = 32'h54000000;
   localparam logic [31:0] MASK_CB       = 32'h7E000000;
   localparam logic [31:0] OP_CBZ        = 32'h34000000;
   localparam logic [31:0] OP_TBZ        = 32'h36000000;
   localparam logic [31:0] MASK_LIT      = 32'h3B000000;
   localparam logic [31:0] OP_LIT        = 32'h18000000;
   localparam logic [31:0] MASK_ADD      = 32'hFF800000;
   localparam logic [31:0] OP_ADD        = 32'h91000000;
   localparam logic [31:0] MASK_MOV      = 32'hFFE0FFE0;
   localparam logic [31:0] OP_MOV64      = 32'hAA0003E0;
   localparam logic [31:0] OP_MOV32      = 32'h2A0003E0;
   localparam logic [31:0] MASK_LDR_UOFF = 32'hFFC00000;
   localparam logic [31:0] OP_LDR64      = 32'hF9400000;
   localparam logic [31:0] OP_LDR32      = 32'hB9400000;
   localparam logic [31:0] MASK_LDR_IDX  = 32'hFFE00400;
   localparam logic [31:0] OP_LDR64_IDX  = 32'hF8400400;
   localparam logic [31:0] OP_LDR32_IDX  = 32'hB8400400;

   // Cross-reference kinds as they appear on the result channel.
   localparam logic [KIND_W-1:0] KIND_ADR      = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LITERAL  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ADRP_ADD = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ADRP_LDR = 2'd3;

   // What the back end does with one decoded item.
   typedef enum logic [2:0] {
      ACT_NOP        = 3'd0,
      ACT_SET_PAGE   = 3'd1,
      ACT_EMIT_PC    = 3'd2,
      ACT_EMIT_TABLE = 3'd3,
      ACT_MOV_COPY   = 3'd4,
      ACT_CLEAR      = 3'd5
   } action_type;

   typedef struct packed {
      action_type              action;
      logic [KIND_W-1:0]       kind;
      logic [REG_FIELD_W-1:0]  src;
      logic [REG_FIELD_W-1:0]  dst;
      logic [ADDR_W-1:0]       base;
      logic [ADDR_W-1:0]       offset;
      logic                    last;
   } queue_entry_type;

endpackage

// ===== hdl/adrp_xref_tracker_core.sv =====
// ADRP cross-reference tracker, top level.
// req_* carries one AArch64 instruction word per item; req_tlast marks the
// final word of a region. The word address is the base address plus four
// times the word's position in the region.
// rsp_* carries zero or one cross-reference per word: the address on
// rsp_tdata and its kind on rsp_tuser (ADR, PC literal, ADRP plus ADD,
// ADRP plus LDR), in the order of the words.
// csr_* writes the base address; it is always ready and should be written
// only while no item is in flight.
// The front end decodes a word in the cycle it is accepted and places it in
// a small queue; the back end takes one queued item per cycle unless its
// result cannot yet be stored, reads the page table, does one 64-bit add and
// loads the result register, which feeds rsp_tvalid. While rsp_tready holds,
// the block sustains one word per cycle, bounded by the single back-end
// table access. When rsp_tready is held low, words with no result drain until
// a word with a result heads the queue; the queue then takes input until it
// fills, then req_tready drops. Reset clears the base address, word position,
// all page valid bits and the queue; page values themselves are never cleared.
module adrp_xref_tracker_core #(
   parameter int NUM_REGS    = 32,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [axt_pkg::INSN_W-1:0]    req_tdata,  // [31:0] insn_word
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [axt_pkg::ADDR_W-1:0]    rsp_tdata,  // [63:0] xref_address
   output logic [axt_pkg::KIND_W-1:0]    rsp_tuser,  // [1:0] xref_kind
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [axt_pkg::ADDR_W-1:0]    csr_data
);

   logic                      push;
   logic                      pop;
   logic                      queue_full;
   logic                      head_valid;
   axt_pkg::queue_entry_type  push_entry;
   axt_pkg::queue_entry_type  head;

   axt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .queue_full (queue_full),
      .push       (push),
      .entry      (push_entry)
   );

   axt_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head       (head)
   );

   axt_back #(
      .NUM_REGS (NUM_REGS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== hdl/axt_front.sv =====
// Front end of the tracker: accepts instruction words, forms the word address
// and decodes each word into a queue entry. Owns the base address register.
// Depends on axt_pkg.
module axt_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [axt_pkg::INSN_W-1:0]    req_tdata,
   input  logic                          req_tlast,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [axt_pkg::ADDR_W-1:0]    csr_data,
   input  logic                          queue_full,
   output logic                          push,
   output axt_pkg::queue_entry_type      entry
);

   logic [axt_pkg::ADDR_W-1:0] base_ff, base_in;
   logic [axt_pkg::ADDR_W-1:0] pos_ff, pos_in;
   logic [axt_pkg::ADDR_W-1:0] pc;
   logic [31:0]                w;
   logic [20:0]                imm21;
   logic [11:0]                imm12;
   logic                       is_skip;
   logic                       is_branch;
   logic                       is_ldr_other;

   assign csr_ready  = 1'b1;
   assign req_tready = !queue_full;
   assign push       = req_tvalid && req_tready;
   assign w          = req_tdata;
   assign pc         = base_ff + {pos_ff[axt_pkg::ADDR_W-3:0], 2'b00};
   assign imm21      = {w[23:5], w[30:29]};
   assign imm12      = w[21:10];

   assign is_skip = ((w & axt_pkg::MASK_BRREG) == axt_pkg::OP_RET)
                 || ((w & axt_pkg::MASK_BRREG) == axt_pkg::OP_BR)
                 || ((w & axt_pkg::MASK_BRREG) == axt_pkg::OP_BLR)
                 || ((w & axt_pkg::MASK_HINT) == axt_pkg::OP_HINT);
   assign is_branch = ((w & axt_pkg::MASK_B) == axt_pkg::OP_B)
                   || ((w & axt_pkg::MASK_BCOND) == axt_pkg::OP_BCOND)
                   || ((w & axt_pkg::MASK_CB) == axt_pkg::OP_CBZ)
                   || ((w & axt_pkg::MASK_CB) == axt_pkg::OP_TBZ);
   assign is_ldr_other = ((w & axt_pkg::MASK_LDR_UOFF) == axt_pkg::OP_LDR32)
                      || ((w & axt_pkg::MASK_LDR_IDX) == axt_pkg::OP_LDR64_IDX)
                      || ((w & axt_pkg::MASK_LDR_IDX) == axt_pkg::OP_LDR32_IDX);

   always_comb begin
      entry        = '0;
      entry.action = axt_pkg::ACT_NOP;
      entry.kind   = axt_pkg::KIND_ADR;
      entry.src    = w[9:5];
      entry.dst    = w[4:0];
      entry.base   = pc;
      entry.offset = '0;
      entry.last   = req_tlast;
      if (is_skip) begin
         entry.action = axt_pkg::ACT_NOP;
      end else if ((w & axt_pkg::MASK_ADR) == axt_pkg::OP_ADR) begin
         if (w[31]) begin
            entry.action = axt_pkg::ACT_SET_PAGE;
            entry.base   = {pc[63:12], 12'h000};
            entry.offset = {{31{imm21[20]}}, imm21, 12'h000};
         end else begin
            entry.action = axt_pkg::ACT_EMIT_PC;
            entry.kind   = axt_pkg::KIND_ADR;
            entry.offset = {{43{imm21[20]}}, imm21};
         end
      end else if (is_branch) begin
         entry.action = axt_pkg::ACT_NOP;
      end else if ((w & axt_pkg::MASK_LIT) == axt_pkg::OP_LIT) begin
         entry.action = axt_pkg::ACT_EMIT_PC;
         entry.kind   = axt_pkg::KIND_LITERAL;
         entry.offset = {{43{w[23]}}, w[23:5], 2'b00};
      end else if ((w & axt_pkg::MASK_ADD) == axt_pkg::OP_ADD) begin
         entry.action = axt_pkg::ACT_EMIT_TABLE;
         entry.kind   = axt_pkg::KIND_ADRP_ADD;
         entry.offset = w[22] ? {40'd0, imm12, 12'h000} : {52'd0, imm12};
      end else if ((w & axt_pkg::MASK_MOV) == axt_pkg::OP_MOV64) begin
         entry.action = axt_pkg::ACT_MOV_COPY;
         entry.src    = w[20:16];
      end else if ((w & axt_pkg::MASK_MOV) == axt_pkg::OP_MOV32) begin
         entry.action = axt_pkg::ACT_CLEAR;
      end else if ((w & axt_pkg::MASK_LDR_UOFF) == axt_pkg::OP_LDR64) begin
         entry.action = axt_pkg::ACT_EMIT_TABLE;
         entry.kind   = axt_pkg::KIND_ADRP_LDR;
         entry.offset = {49'd0, imm12, 3'b000};
      end else if (is_ldr_other) begin
         entry.action = axt_pkg::ACT_CLEAR;
      end
   end

   always_comb begin
      base_in = base_ff;
      if (csr_valid && csr_ready) begin
         base_in = csr_data;
      end
      pos_in = pos_ff;
      if (push) begin
         pos_in = req_tlast ? '0 : pos_ff + 64'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         pos_ff  <= '0;
      end else begin
         base_ff <= base_in;
         pos_ff  <= pos_in;
      end
   end

`ifndef SYNTH
   a_last_restarts_region: assert property (@(posedge clock) disable iff (reset)
      (push && req_tlast) |=> (pos_ff == '0)) else $error("position not cleared after last word");
   a_position_steps: assert property (@(posedge clock) disable iff (reset)
      (push && !req_tlast) |=> (pos_ff == $past(pos_ff) + 64'd1))
      else $error("position did not advance by one word");
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      queue_full |-> !push) else $error("item accepted while the queue is full");
`endif

endmodule

// ===== hdl/axt_queue.sv =====
// Short queue of decoded items between the front end and the back end.
// Registered entries with read and write pointers. Depends on axt_pkg.
module axt_queue #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  axt_pkg::queue_entry_type  push_entry,
   input  logic                      pop,
   output logic                      full,
   output logic                      head_valid,
   output axt_pkg::queue_entry_type  head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   axt_pkg::queue_entry_type entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTH
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH)) else $error("queue count exceeds depth");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid) else $error("pop from an empty queue");
   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a push");
`endif

endmodule

// ===== hdl/axt_back.sv =====
// Back end of the tracker: holds the page table and valid bits, carries out
// each decoded item and drives the registered result channel. Depends on axt_pkg.
module axt_back #(
   parameter int NUM_REGS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  axt_pkg::queue_entry_type      head,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [axt_pkg::ADDR_W-1:0]    rsp_tdata,
   output logic [axt_pkg::KIND_W-1:0]    rsp_tuser
);

   localparam int IDX_W = $clog2(NUM_REGS);

   logic [axt_pkg::ADDR_W-1:0] page_ff [NUM_REGS];
   logic [NUM_REGS-1:0]        valid_ff, valid_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [axt_pkg::ADDR_W-1:0] rsp_addr_ff;
   logic [axt_pkg::KIND_W-1:0] rsp_kind_ff;
   logic [IDX_W-1:0]           src_idx;
   logic [IDX_W-1:0]           dst_idx;
   logic [axt_pkg::ADDR_W-1:0] src_value;
   logic                       src_valid;
   logic                       from_table;
   logic [axt_pkg::ADDR_W-1:0] sum;
   logic                       emit;
   logic                       out_free;
   logic                       page_we;

   assign src_idx    = head.src[IDX_W-1:0];
   assign dst_idx    = head.dst[IDX_W-1:0];
   assign src_value  = page_ff[src_idx];
   assign src_valid  = valid_ff[src_idx];
   assign from_table = (head.action == axt_pkg::ACT_EMIT_TABLE)
                    || (head.action == axt_pkg::ACT_MOV_COPY);
   // One shared adder: pc-relative forms add to the word address, table forms
   // add to the tracked page value (a register move adds zero).
   assign sum        = (from_table ? src_value : head.base) + head.offset;
   assign emit       = (head.action == axt_pkg::ACT_EMIT_PC)
                    || ((head.action == axt_pkg::ACT_EMIT_TABLE) && src_valid);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign pop        = head_valid && (!emit || out_free);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = rsp_kind_ff;

   always_comb begin
      valid_in = valid_ff;
      page_we  = 1'b0;
      if (pop) begin
         case (head.action)
            axt_pkg::ACT_SET_PAGE: begin
               valid_in[dst_idx] = 1'b1;
               page_we           = 1'b1;
            end
            axt_pkg::ACT_MOV_COPY: begin
               valid_in[dst_idx] = src_valid;
               page_we           = src_valid;
            end
            axt_pkg::ACT_EMIT_PC, axt_pkg::ACT_EMIT_TABLE, axt_pkg::ACT_CLEAR: begin
               valid_in[dst_idx] = 1'b0;
            end
            default: begin
               valid_in = valid_ff;
            end
         endcase
         if (head.last) begin
            valid_in = '0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         rsp_addr_ff <= sum;
         rsp_kind_ff <= head.kind;
      end
   end

   always_ff @(posedge clock) begin
      if (page_we) begin
         page_ff[dst_idx] <= sum;
      end
   end

`ifndef SYNTH
   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      (pop && emit) |-> out_free) else $error("result issued over a waiting result");
   a_region_end_clears: assert property (@(posedge clock) disable iff (reset)
      (pop && head.last) |=> (valid_ff == '0)) else $error("valid bits survive region end");
   a_page_set_valid: assert property (@(posedge clock) disable iff (reset)
      (pop && !head.last && head.action == axt_pkg::ACT_SET_PAGE)
      |=> valid_ff[$past(dst_idx)]) else $error("page entry not marked valid");
`endif

endmodule
